// File: src/rlp_pkg.sv
// ----------------------------------------------------------------------------
// rlp_pkg
// Shared types, constants and the prefix table for the range line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rlp_pkg;

  // Line buffer capacity in characters (one slot is kept for the terminator)
  localparam int unsigned LINE_CAPACITY_DEF = 128;

  // Field widths
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned CM_W    = 10;
  localparam int unsigned VALUE_W = 11;
  localparam int unsigned MM_W    = 15;

  // Reset value of max_cm and the accumulator saturation point
  localparam logic [CM_W-1:0]    MAX_CM_RESET = 10'd600;
  localparam logic [VALUE_W-1:0] DIGIT_SAT    = 11'd2047;

  // Length of the "Range " prefix
  localparam int unsigned PREFIX_LEN = 6;

  // Distance reported while no target is present (-1 in 15 bits)
  localparam logic [MM_W-1:0] ABSENT_MM = 15'h7FFF;

  // Characters with special meaning
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // Parser phase within one line
  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_SPACE,
    PH_SIGNED,
    PH_DIGITS,
    PH_DONE,
    PH_REJECT
  } phase_t;

  // Line status handed from the character scanner to the report logic
  typedef struct packed {
    logic                line_used;   // at least one character stored
    logic                has_number;  // digits were read after the prefix
    logic                negative;    // a minus sign was seen
    logic [VALUE_W-1:0]  value;       // saturated magnitude
  } line_status_t;

  // Expected character at each prefix position
  function automatic logic [CHAR_W-1:0] prefix_char(input logic [2:0] idx);
    logic [CHAR_W-1:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h52;  // R
      3'd1:    ch = 8'h61;  // a
      3'd2:    ch = 8'h6E;  // n
      3'd3:    ch = 8'h67;  // g
      3'd4:    ch = 8'h65;  // e
      3'd5:    ch = 8'h20;  // space
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: src/rlp_line_scan.sv
// ----------------------------------------------------------------------------
// rlp_line_scan
// Per-character scanner: tracks line position, matches the prefix and
// accumulates the decimal value of the current line.
// ----------------------------------------------------------------------------
`default_nettype none

module rlp_line_scan #(
  parameter int unsigned LINE_CAPACITY = rlp_pkg::LINE_CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          char_valid,  // non-terminator transaction
  input  logic                          line_end,    // terminator transaction
  input  logic [rlp_pkg::CHAR_W-1:0]    rx_byte,
  output rlp_pkg::line_status_t         status
);

  import rlp_pkg::*;

  localparam int unsigned      PosW    = $clog2(LINE_CAPACITY);
  localparam logic [PosW-1:0]  LastPos = PosW'(LINE_CAPACITY - 1);
  localparam logic [PosW-1:0]  PfxLast = PosW'(PREFIX_LEN - 1);
  localparam logic [PosW-1:0]  PfxLen  = PosW'(PREFIX_LEN);

  // Line state
  logic [PosW-1:0]     line_position, line_position_next;
  phase_t              parse_phase, parse_phase_next;
  logic                negative_sign, negative_sign_next;
  logic [VALUE_W-1:0]  digit_value, digit_value_next;
  logic                digits_seen, digits_seen_next;

  // Character classes
  logic                is_digit;
  logic                is_blank;
  logic                is_sign;
  logic                prefix_hit;
  logic                store;
  logic [MM_W-1:0]     acc_sum;
  logic [VALUE_W-1:0]  acc_sat;

  assign is_digit   = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign is_blank   = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) ||
                      (rx_byte == CH_VT) || (rx_byte == CH_FF);
  assign is_sign    = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);
  assign prefix_hit = (line_position < PfxLen) &&
                      (rx_byte == prefix_char(line_position[2:0]));
  assign store      = char_valid && (line_position < LastPos);

  // value*10 + digit, saturated
  assign acc_sum = (MM_W'(digit_value) * MM_W'(10)) + MM_W'(rx_byte[3:0]);
  assign acc_sat = (acc_sum > MM_W'(DIGIT_SAT)) ? DIGIT_SAT : acc_sum[VALUE_W-1:0];

  // Next line state
  always_comb begin
    line_position_next = line_position;
    parse_phase_next   = parse_phase;
    negative_sign_next = negative_sign;
    digit_value_next   = digit_value;
    digits_seen_next   = digits_seen;
    if (line_end) begin
      line_position_next = '0;
      parse_phase_next   = PH_PREFIX;
      negative_sign_next = 1'b0;
      digit_value_next   = '0;
      digits_seen_next   = 1'b0;
    end else if (store) begin
      line_position_next = line_position + 1'b1;
      unique case (parse_phase)
        PH_PREFIX: begin
          if (!prefix_hit) begin
            parse_phase_next = PH_REJECT;
          end else if (line_position == PfxLast) begin
            parse_phase_next = PH_SPACE;
          end
        end
        PH_SPACE: begin
          priority if (is_blank) begin
            parse_phase_next = PH_SPACE;
          end else if (is_sign) begin
            negative_sign_next = (rx_byte == CH_MINUS);
            parse_phase_next   = PH_SIGNED;
          end else if (is_digit) begin
            digit_value_next = acc_sat;
            digits_seen_next = 1'b1;
            parse_phase_next = PH_DIGITS;
          end else begin
            parse_phase_next = PH_DONE;
          end
        end
        PH_SIGNED, PH_DIGITS: begin
          if (is_digit) begin
            digit_value_next = acc_sat;
            digits_seen_next = 1'b1;
            parse_phase_next = PH_DIGITS;
          end else begin
            parse_phase_next = PH_DONE;
          end
        end
        default: begin
          parse_phase_next = parse_phase;
        end
      endcase
    end
  end

  // Line state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_position <= '0;
      parse_phase   <= PH_PREFIX;
      negative_sign <= 1'b0;
      digit_value   <= '0;
      digits_seen   <= 1'b0;
    end else begin
      line_position <= line_position_next;
      parse_phase   <= parse_phase_next;
      negative_sign <= negative_sign_next;
      digit_value   <= digit_value_next;
      digits_seen   <= digits_seen_next;
    end
  end

  // Status of the line as it stands
  always_comb begin
    status.line_used  = (line_position != '0);
    status.has_number = digits_seen &&
                        ((parse_phase == PH_SIGNED) || (parse_phase == PH_DIGITS) ||
                         (parse_phase == PH_DONE));
    status.negative   = negative_sign;
    status.value      = digit_value;
  end

endmodule

`default_nettype wire

// File: src/range_line_parser_core.sv
// Reports: a report is registered and appears on the master side in the cycle
//   after the line terminator transaction is accepted.
// Throughput: one character per cycle; the input stalls only while a report
//   sits in the output register and the master side is not ready.
// Reset (rst, synchronous): line cleared, no target present, max_cm = 600.
// ----------------------------------------------------------------------------
// range_line_parser_core
// Splits received characters into lines and reports changes of target presence
// and distance from "Range <n>" lines.
// ----------------------------------------------------------------------------
`default_nettype none

module range_line_parser_core #(
  parameter int unsigned LINE_CAPACITY = rlp_pkg::LINE_CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration: max_cm
  input  logic                        cfg_we,
  input  logic [rlp_pkg::CM_W-1:0]    cfg_wdata,
  // received characters
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] rx_byte
  // reports
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata    // [0] report_present,
                                                      // [15:1] report_distance_mm
);

  import rlp_pkg::*;

  logic [CM_W-1:0]     max_cm_reg;
  logic                present_flag;
  logic [MM_W-1:0]     last_distance;   // two's complement, -1 after reset
  logic                out_present;
  logic [MM_W-1:0]     out_distance;

  logic                s_xfer;
  logic                is_term;
  logic                char_valid;
  logic                line_end;
  line_status_t        status;

  logic                accepted;
  logic                present_new;
  logic [MM_W-1:0]     mm_new;
  logic                changed;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign is_term       = (s_axis_tdata == CH_LF) || (s_axis_tdata == CH_CR);
  assign char_valid    = s_xfer && !is_term;
  assign line_end      = s_xfer && is_term;

  // Character scanner
  rlp_line_scan #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .line_end   (line_end),
    .rx_byte    (s_axis_tdata),
    .status     (status)
  );

  // Line verdict at the terminator
  assign accepted    = line_end && status.line_used && status.has_number &&
                       (!status.negative || (status.value == '0)) &&
                       (status.value <= VALUE_W'(max_cm_reg));
  assign present_new = (status.value != '0);
  assign mm_new      = MM_W'(status.value) * MM_W'(10);
  assign changed     = (present_new != present_flag) ||
                       (present_new && (mm_new != last_distance));

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_cm_reg <= MAX_CM_RESET;
    end else if (cfg_we) begin
      max_cm_reg <= cfg_wdata;
    end
  end

  // Target state
  always_ff @(posedge clk) begin
    if (rst) begin
      present_flag  <= 1'b0;
      last_distance <= ABSENT_MM;
    end else if (accepted) begin
      present_flag  <= present_new;
      last_distance <= mm_new;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accepted && changed) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accepted && changed) begin
      out_present  <= present_new;
      out_distance <= present_new ? mm_new : ABSENT_MM;
    end
  end

  assign m_axis_tdata = {out_distance, out_present};

endmodule

`default_nettype wire
